@@ rtl/qslsf_pkg.sv @@
// ----------------------------------------------------------------------------
// qslsf_pkg
// Shared widths, item types and term tables of the quadratic surface fit.
// ----------------------------------------------------------------------------
package qslsf_pkg;

  localparam int NTERMS         = 6;
  localparam int NCOLS          = 7;
  localparam int NMONO          = 15;
  localparam int NSUMS          = 21;
  localparam int COORD_W        = 10;
  localparam int TGT_W          = 12;
  localparam int MON_W          = 4 * COORD_W;
  localparam int TERM_W         = 2 * COORD_W;
  localparam int FRAC_BITS      = 40;
  localparam int COEF_W         = 64;
  localparam int IDX_W          = 3;
  localparam int SUM_IDX_W      = 5;
  localparam int MAX_POINTS_DEF = 64;

  // Calibration point after classification by the front
  typedef struct packed {
    logic [COORD_W-1:0] eye_x;
    logic [COORD_W-1:0] eye_y;
    logic [TGT_W-1:0]   target;
    logic               accum;
    logic               last;
    logic               enough;
  } pt_t;

  // One fitted coefficient
  typedef struct packed {
    logic signed [COEF_W-1:0] coefficient;
    logic [IDX_W-1:0]         coeff_index;
    logic                     singular;
    logic                     last_coeff;
  } res_t;

  // Power of x of each fitted term: 1, x, x^2, xy, y, y^2
  function automatic logic [2:0] term_a(input logic [IDX_W-1:0] t);
    logic [2:0] r;
    case (t)
      3'd1:    r = 3'd1;
      3'd2:    r = 3'd2;
      3'd3:    r = 3'd1;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // Power of y of each fitted term
  function automatic logic [2:0] term_b(input logic [IDX_W-1:0] t);
    logic [2:0] r;
    case (t)
      3'd3:    r = 3'd1;
      3'd4:    r = 3'd1;
      3'd5:    r = 3'd2;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // Moments are grouped by power of y, power of x rising within a group
  function automatic logic [SUM_IDX_W-1:0] mono_idx(input logic [2:0] a, input logic [2:0] b);
    logic [SUM_IDX_W-1:0] base;
    case (b)
      3'd1:    base = 5'd5;
      3'd2:    base = 5'd9;
      3'd3:    base = 5'd12;
      3'd4:    base = 5'd14;
      default: base = 5'd0;
    endcase
    return base + SUM_IDX_W'(a);
  endfunction

  // Power of x of a moment index
  function automatic logic [2:0] mono_a(input logic [SUM_IDX_W-1:0] m);
    logic [2:0] r;
    case (m)
      5'd1, 5'd6, 5'd10, 5'd13: r = 3'd1;
      5'd2, 5'd7, 5'd11:        r = 3'd2;
      5'd3, 5'd8:               r = 3'd3;
      5'd4:                     r = 3'd4;
      default:                  r = 3'd0;
    endcase
    return r;
  endfunction

  // Sum that seeds one entry of the augmented normal matrix
  function automatic logic [SUM_IDX_W-1:0] load_idx(input logic [IDX_W-1:0] r,
                                                   input logic [IDX_W-1:0] c);
    logic [SUM_IDX_W-1:0] v;
    if (c == IDX_W'(NTERMS)) begin
      v = SUM_IDX_W'(NMONO) + SUM_IDX_W'(r);
    end else begin
      v = mono_idx(term_a(r) + term_a(c), term_b(r) + term_b(c));
    end
    return v;
  endfunction

endpackage

@@ rtl/qslsf_fifo.sv @@
// ----------------------------------------------------------------------------
// qslsf_fifo
// Small first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module qslsf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store_r[rp_r];

  // Hold entries, advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        store_r[wp_r] <= wdata;
        wp_r          <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/qslsf_front.sv @@
// ----------------------------------------------------------------------------
// qslsf_front
// Accepts calibration points, counts them and tags each one: accumulate or
// drop past the point limit, end of set, enough points for a solve.
// ----------------------------------------------------------------------------
module qslsf_front #(
  parameter int MAX_POINTS = qslsf_pkg::MAX_POINTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  logic [qslsf_pkg::COORD_W-1:0]   eye_x,
  input  logic [qslsf_pkg::COORD_W-1:0]   eye_y,
  input  logic [qslsf_pkg::TGT_W-1:0]     target,
  input  logic                            last_point,
  input  logic                            q_full,
  output logic                            q_push,
  output qslsf_pkg::pt_t                  q_data
);

  import qslsf_pkg::*;

  localparam int CW = $clog2(MAX_POINTS + 1);

  logic [CW-1:0] count_r, count_nxt, count_after;
  logic          accum;

  // Classify the point against the running count
  assign accum       = (count_r < CW'(MAX_POINTS));
  assign count_after = accum ? count_r + 1'b1 : count_r;
  assign count_nxt   = last_point ? '0 : count_after;
  assign q_push      = push && !q_full;

  always_comb begin
    q_data.eye_x  = eye_x;
    q_data.eye_y  = eye_y;
    q_data.target = target;
    q_data.accum  = accum;
    q_data.last   = last_point;
    q_data.enough = (count_after >= CW'(NTERMS));
  end

  // Advance the count on each accumulated point, restart after the last point of a set
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (q_push) begin
      count_r <= count_nxt;
    end
  end

endmodule

@@ rtl/qslsf_back.sv @@
// ----------------------------------------------------------------------------
// qslsf_back
// Accumulates moments of queued points and, at the end of a set, solves the
// normal equations by fraction-free Gauss-Jordan elimination on a bit-serial
// multiply-accumulate unit and a restoring divider.
// ----------------------------------------------------------------------------
module qslsf_back #(
  parameter int MAX_POINTS = qslsf_pkg::MAX_POINTS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  qslsf_pkg::pt_t q_data,
  input  logic           q_empty,
  output logic           q_pop,
  input  logic           res_full,
  output logic           res_push,
  output qslsf_pkg::res_t res_data
);

  import qslsf_pkg::*;

  localparam int CW     = $clog2(MAX_POINTS + 1);
  localparam int SB     = MON_W + CW;
  localparam int W      = NTERMS * SB + 10;
  localparam int AW     = 2 * W + 2;
  localparam int CNT_W  = $clog2(AW + 1);
  localparam int ADDR_W = $clog2(NTERMS * NCOLS);

  typedef enum logic [4:0] {
    S_IDLE, S_ACC, S_PTEND, S_LOAD, S_PV_RD, S_PV_CHK, S_RF, S_RFW, S_RA, S_RB,
    S_RBW, S_MUL, S_DVS, S_DIV, S_WB, S_ON, S_OD, S_ODW, S_RND, S_PUSH, S_SING
  } state_t;

  state_t state_r;
  pt_t    pt_r;

  logic [SUM_IDX_W-1:0] step_r;
  logic [MON_W-1:0]     cur_r, rowst_r;
  logic [TERM_W-1:0]    termv_r [NTERMS];
  logic [SB-1:0]        sums_r [NSUMS];

  logic [W-1:0]         mat [NTERMS*NCOLS];
  logic [W-1:0]         rdata_r;
  logic [ADDR_W-1:0]    mem_addr;
  logic                 mem_we;
  logic [W-1:0]         mem_wdata;

  logic [IDX_W-1:0]     i_r, j_r, k_r, p_r;
  logic [IDX_W-1:0]     perm_r [NTERMS];
  logic [IDX_W-1:0]     perm_sel, prow;

  logic [W-1:0]         piv_r, prev_r, f_r, a_r, b_r, num_r;
  logic [AW-1:0]        acc_r, mc_r, dq_r;
  logic [W-1:0]         mq_r, rem_r, dvs_r;
  logic                 msign_r, second_r, qsign_r, q40_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [COEF_W-1:0]    coef_r;

  logic [SUM_IDX_W-1:0] sum_idx;
  logic [SB-1:0]        sum_rd, acc_add;
  logic [2:0]           nx_a;
  logic [MON_W-1:0]     mul_a, mon_nxt;
  logic [COORD_W-1:0]   mul_b;
  logic [IDX_W-1:0]     tv_idx;
  logic [W:0]           r2, r2x;
  logic                 ge, rnd, big;
  logic [AW:0]          q1;
  logic [COEF_W-1:0]    sat;
  logic [AW-1:0]        acc_mag;
  logic [W-1:0]         qmag;
  logic [IDX_W-1:0]     nrow;

  function automatic logic [W-1:0] mag_w(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  // Moment datapath: next monomial and the value added to the current sum
  assign nx_a    = mono_a(step_r + 1'b1);
  assign mul_a   = (nx_a == '0) ? rowst_r : cur_r;
  assign mul_b   = (nx_a == '0) ? pt_r.eye_y : pt_r.eye_x;
  assign mon_nxt = MON_W'(mul_a * mul_b);
  assign tv_idx  = IDX_W'(step_r - SUM_IDX_W'(NMONO));
  assign acc_add = (step_r < SUM_IDX_W'(NMONO)) ? SB'(cur_r)
                                                : SB'(pt_r.target) * SB'(termv_r[tv_idx]);
  assign sum_idx = (state_r == S_LOAD) ? load_idx(i_r, j_r) : step_r;
  assign sum_rd  = sums_r[sum_idx];

  // Divider step, rounding and saturation
  assign r2      = {rem_r, dq_r[AW-1]};
  assign ge      = (r2 >= {1'b0, dvs_r});
  assign r2x     = {rem_r, 1'b0};
  assign rnd     = (r2x >= {1'b0, dvs_r});
  assign q1      = {1'b0, dq_r} + (AW+1)'(rnd);
  assign big     = |q1[AW:COEF_W-1];
  assign acc_mag = acc_r[AW-1] ? (~acc_r + 1'b1) : acc_r;
  assign qmag    = dq_r[W-1:0];

  always_comb begin
    if (qsign_r) begin
      sat = big ? {1'b1, {(COEF_W-1){1'b0}}} : (~{1'b0, q1[COEF_W-2:0]} + 1'b1);
    end else begin
      sat = big ? {1'b0, {(COEF_W-1){1'b1}}} : {1'b0, q1[COEF_W-2:0]};
    end
  end

  // Next row to eliminate, skipping the pivot row
  assign nrow = (i_r + 1'b1 == k_r) ? i_r + 3'd2 : i_r + 1'b1;

  // Matrix port: one access a cycle, physical rows through the permutation
  always_comb begin
    case (state_r)
      S_PV_RD: perm_sel = p_r;
      S_RB:    perm_sel = k_r;
      default: perm_sel = i_r;
    endcase
    prow      = perm_r[perm_sel];
    mem_we    = 1'b0;
    mem_wdata = qsign_r ? (~qmag + 1'b1) : qmag;
    case (state_r)
      S_LOAD: begin
        mem_addr  = ADDR_W'(i_r) * ADDR_W'(NCOLS) + ADDR_W'(j_r);
        mem_we    = 1'b1;
        mem_wdata = W'(sum_rd);
      end
      S_PV_RD, S_RF: mem_addr = ADDR_W'(prow) * ADDR_W'(NCOLS) + ADDR_W'(k_r);
      S_RA, S_RB:    mem_addr = ADDR_W'(prow) * ADDR_W'(NCOLS) + ADDR_W'(j_r);
      S_WB: begin
        mem_addr = ADDR_W'(prow) * ADDR_W'(NCOLS) + ADDR_W'(j_r);
        mem_we   = 1'b1;
      end
      S_ON:    mem_addr = ADDR_W'(prow) * ADDR_W'(NCOLS) + ADDR_W'(NTERMS);
      S_OD:    mem_addr = ADDR_W'(prow) * ADDR_W'(NCOLS) + ADDR_W'(i_r);
      default: mem_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mat[mem_addr] <= mem_wdata;
    end
    rdata_r <= mat[mem_addr];
  end

  // Handshakes toward the queues
  assign q_pop    = (state_r == S_IDLE) && !q_empty;
  assign res_push = ((state_r == S_PUSH) || (state_r == S_SING)) && !res_full;

  always_comb begin
    res_data.coefficient = (state_r == S_PUSH) ? coef_r : '0;
    res_data.coeff_index = i_r;
    res_data.singular    = (state_r == S_SING);
    res_data.last_coeff  = (i_r == IDX_W'(NTERMS - 1));
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int s = 0; s < NSUMS; s++) begin
        sums_r[s] <= '0;
      end
    end else begin
      unique case (state_r)
        // Take the next point
        S_IDLE: begin
          if (!q_empty) begin
            pt_r    <= q_data;
            step_r  <= '0;
            cur_r   <= MON_W'(1);
            rowst_r <= MON_W'(1);
            state_r <= q_data.accum ? S_ACC : S_PTEND;
          end
        end
        // Add one moment a cycle
        S_ACC: begin
          sums_r[step_r] <= sum_rd + acc_add;
          for (int t = 0; t < NTERMS; t++) begin
            if (step_r == mono_idx(term_a(IDX_W'(t)), term_b(IDX_W'(t)))) begin
              termv_r[t] <= cur_r[TERM_W-1:0];
            end
          end
          cur_r <= mon_nxt;
          if (nx_a == '0) begin
            rowst_r <= mon_nxt;
          end
          step_r <= step_r + 1'b1;
          if (step_r == SUM_IDX_W'(NSUMS - 1)) begin
            state_r <= S_PTEND;
          end
        end
        S_PTEND: begin
          i_r <= '0;
          j_r <= '0;
          if (!pt_r.last) begin
            state_r <= S_IDLE;
          end else if (pt_r.enough) begin
            state_r <= S_LOAD;
          end else begin
            for (int s = 0; s < NSUMS; s++) begin
              sums_r[s] <= '0;
            end
            state_r <= S_SING;
          end
        end
        // Build the augmented matrix, then drop the sums
        S_LOAD: begin
          if (j_r == IDX_W'(NTERMS)) begin
            j_r <= '0;
            if (i_r == IDX_W'(NTERMS - 1)) begin
              for (int s = 0; s < NSUMS; s++) begin
                sums_r[s] <= '0;
              end
              for (int t = 0; t < NTERMS; t++) begin
                perm_r[t] <= IDX_W'(t);
              end
              k_r     <= '0;
              p_r     <= '0;
              prev_r  <= W'(1);
              state_r <= S_PV_RD;
            end else begin
              i_r <= i_r + 1'b1;
            end
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        // Search the pivot column for a nonzero entry
        S_PV_RD: state_r <= S_PV_CHK;
        S_PV_CHK: begin
          if (rdata_r != '0) begin
            perm_r[p_r] <= perm_r[k_r];
            perm_r[k_r] <= perm_r[p_r];
            piv_r       <= rdata_r;
            i_r         <= (k_r == '0) ? IDX_W'(1) : '0;
            state_r     <= S_RF;
          end else if (p_r == IDX_W'(NTERMS - 1)) begin
            i_r     <= '0;
            state_r <= S_SING;
          end else begin
            p_r     <= p_r + 1'b1;
            state_r <= S_PV_RD;
          end
        end
        // Fetch the row factor, then each element and its pivot-row partner
        S_RF: state_r <= S_RFW;
        S_RFW: begin
          f_r     <= rdata_r;
          j_r     <= '0;
          state_r <= S_RA;
        end
        S_RA: state_r <= S_RB;
        S_RB: begin
          a_r     <= rdata_r;
          state_r <= S_RBW;
        end
        S_RBW: begin
          b_r      <= rdata_r;
          mq_r     <= mag_w(piv_r);
          mc_r     <= AW'(mag_w(a_r));
          msign_r  <= piv_r[W-1] ^ a_r[W-1];
          acc_r    <= '0;
          second_r <= 1'b0;
          cnt_r    <= '0;
          state_r  <= S_MUL;
        end
        // pivot * element - factor * partner, one multiplier bit a cycle
        S_MUL: begin
          if (mq_r[0]) begin
            acc_r <= msign_r ? acc_r - mc_r : acc_r + mc_r;
          end
          if (cnt_r == CNT_W'(W - 1)) begin
            cnt_r <= '0;
            if (!second_r) begin
              second_r <= 1'b1;
              mq_r     <= mag_w(f_r);
              mc_r     <= AW'(mag_w(b_r));
              msign_r  <= ~(f_r[W-1] ^ b_r[W-1]);
            end else begin
              state_r <= S_DVS;
            end
          end else begin
            cnt_r <= cnt_r + 1'b1;
            mq_r  <= mq_r >> 1;
            mc_r  <= mc_r << 1;
          end
        end
        S_DVS: begin
          dq_r    <= acc_mag;
          dvs_r   <= mag_w(prev_r);
          qsign_r <= acc_r[AW-1] ^ prev_r[W-1];
          rem_r   <= '0;
          cnt_r   <= '0;
          q40_r   <= 1'b0;
          state_r <= S_DIV;
        end
        // Restoring division, one quotient bit a cycle
        S_DIV: begin
          rem_r <= ge ? W'(r2 - {1'b0, dvs_r}) : r2[W-1:0];
          dq_r  <= {dq_r[AW-2:0], ge};
          if (cnt_r == CNT_W'(AW - 1)) begin
            state_r <= q40_r ? S_RND : S_WB;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        // Store the element, advance column, row and pivot step
        S_WB: begin
          if (j_r == IDX_W'(NTERMS)) begin
            if (nrow > IDX_W'(NTERMS - 1)) begin
              prev_r <= piv_r;
              if (k_r == IDX_W'(NTERMS - 1)) begin
                i_r     <= '0;
                state_r <= S_ON;
              end else begin
                k_r     <= k_r + 1'b1;
                p_r     <= k_r + 1'b1;
                state_r <= S_PV_RD;
              end
            end else begin
              i_r     <= nrow;
              state_r <= S_RF;
            end
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_RA;
          end
        end
        // Coefficient = right-hand side over diagonal, scaled to Q23.40
        S_ON: state_r <= S_OD;
        S_OD: begin
          num_r   <= rdata_r;
          state_r <= S_ODW;
        end
        S_ODW: begin
          dq_r    <= AW'(mag_w(num_r)) << FRAC_BITS;
          dvs_r   <= mag_w(rdata_r);
          qsign_r <= num_r[W-1] ^ rdata_r[W-1];
          rem_r   <= '0;
          cnt_r   <= '0;
          q40_r   <= 1'b1;
          state_r <= S_DIV;
        end
        S_RND: begin
          coef_r  <= sat;
          state_r <= S_PUSH;
        end
        S_PUSH, S_SING: begin
          if (!res_full) begin
            if (i_r == IDX_W'(NTERMS - 1)) begin
              state_r <= S_IDLE;
            end else begin
              i_r     <= i_r + 1'b1;
              state_r <= (state_r == S_PUSH) ? S_ON : S_SING;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/quadratic_surface_least_squares_fit_top.sv @@
// ----------------------------------------------------------------------------
// quadratic_surface_least_squares_fit_top
// Least-squares fit of target = c0 + c1 x + c2 x^2 + c3 xy + c4 y + c5 y^2.
// ----------------------------------------------------------------------------
// Points are queued behind a two-entry queue; each accumulated point is taken,
// its 21 sums are added by the moment unit one a cycle, and it is checked; a point
// past MAX_POINTS is only taken and checked. The point marked last starts an exact
// solve on the bit-serial multiply-accumulate unit and the restoring divider, with
// matrix entries W = 6 * (40 + clog2(MAX_POINTS + 1)) + 10 bits wide and products
// and dividends AW = 2W + 2 bits wide, over one matrix port. Fewer than six points
// give six zero coefficients with singular set at once; a singular matrix ends
// the solve at the first pivot column without a nonzero entry, with the same
// result.
// ----------------------------------------------------------------------------
module quadratic_surface_least_squares_fit_top #(
  parameter int MAX_POINTS = qslsf_pkg::MAX_POINTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_push,
  output logic                                  in_full,
  input  logic [qslsf_pkg::COORD_W-1:0]         in_eye_x,
  input  logic [qslsf_pkg::COORD_W-1:0]         in_eye_y,
  input  logic [qslsf_pkg::TGT_W-1:0]           in_target,
  input  logic                                  in_last_point,
  output logic                                  out_empty,
  input  logic                                  out_pop,
  output logic signed [qslsf_pkg::COEF_W-1:0]   out_coefficient,
  output logic [qslsf_pkg::IDX_W-1:0]           out_coeff_index,
  output logic                                  out_singular,
  output logic                                  out_last_coeff
);

  import qslsf_pkg::*;

  logic q_push, q_full, q_pop, q_empty;
  pt_t  q_wdata, q_rdata;
  logic res_push, res_full;
  res_t res_wdata, res_rdata;

  assign in_full = q_full;

  qslsf_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_push),
    .eye_x      (in_eye_x),
    .eye_y      (in_eye_y),
    .target     (in_target),
    .last_point (in_last_point),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  qslsf_fifo #(.WIDTH($bits(pt_t)), .DEPTH(2)) u_pt_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  qslsf_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_data   (q_rdata),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_data (res_wdata)
  );

  qslsf_fifo #(.WIDTH($bits(res_t)), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty)
  );

  assign out_coefficient = res_rdata.coefficient;
  assign out_coeff_index = res_rdata.coeff_index;
  assign out_singular    = res_rdata.singular;
  assign out_last_coeff  = res_rdata.last_coeff;

endmodule

@@ rtl/qslsf_chk.sv @@
// ----------------------------------------------------------------------------
// qslsf_chk
// Port-level checks on the coefficient stream of the fit.
// ----------------------------------------------------------------------------
module qslsf_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_empty,
  input logic                                out_pop,
  input logic signed [qslsf_pkg::COEF_W-1:0] out_coefficient,
  input logic [qslsf_pkg::IDX_W-1:0]         out_coeff_index,
  input logic                                out_singular,
  input logic                                out_last_coeff
);

  // End of set marks exactly the sixth coefficient
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_last_coeff == (out_coeff_index == 3'd5)))
    else $error("last_coeff does not match coefficient index");

  // A singular fit reports zero coefficients
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_singular) |-> (out_coefficient == '0))
    else $error("singular result carries a nonzero coefficient");

  // Coefficients of a set come out in term order
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && !out_last_coeff) |=>
      (out_empty || (out_coeff_index == $past(out_coeff_index) + 3'd1)))
    else $error("coefficient index out of order");

  // A waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_coefficient) && $stable(out_coeff_index)))
    else $error("waiting result changed");

endmodule

bind quadratic_surface_least_squares_fit_top qslsf_chk u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_coefficient (out_coefficient),
  .out_coeff_index (out_coeff_index),
  .out_singular    (out_singular),
  .out_last_coeff  (out_last_coeff)
);
